@@ src/dmd_pkg.sv @@
// ----------------------------------------------------------------------------
// dmd_pkg
// Shared types, character constants and the accent table for the entry
// markup decoder.
// ----------------------------------------------------------------------------
package dmd_pkg;

    localparam int unsigned MaxResults = 4;

    typedef enum logic [1:0] {
        KIND_PLAIN   = 2'd0,
        KIND_RUNE    = 2'd1,
        KIND_NEWLINE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_FULL = 2'd0,
        MODE_HEAD = 2'd1,
        MODE_RAW  = 2'd2
    } mode_t;

    typedef enum logic [6:0] {
        PH_NORMAL      = 7'b0000001,
        PH_STAR        = 7'b0000010,
        PH_STAR_S      = 7'b0000100,
        PH_HASH        = 7'b0001000,
        PH_HASH_LETTER = 7'b0010000,
        PH_SPACE       = 7'b0100000,
        PH_STOPPED     = 7'b1000000
    } phase_t;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_FIVE   = 8'h35;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_C      = 8'h63;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_O      = 8'h6F;

    // Up to four results from one byte, slot 0 goes out first
    typedef struct packed {
        logic [2:0]       count;
        logic [3:0][1:0]  kind;
        logic [3:0][7:0]  code;
    } group_t;

    // Accented rune for letter and accent number 0..4
    function automatic logic [7:0] accent_rune(input logic [7:0] letter,
                                               input logic [2:0] idx);
        logic [7:0] r;
        r = letter;
        case (letter)
            CH_A: begin
                case (idx)
                    3'd0:    r = 8'hE1;
                    3'd1:    r = 8'hE0;
                    3'd2:    r = 8'hE2;
                    3'd3:    r = 8'hE4;
                    default: r = 8'h61;
                endcase
            end
            CH_E: begin
                case (idx)
                    3'd0:    r = 8'hE9;
                    3'd1:    r = 8'hE8;
                    3'd2:    r = 8'hEA;
                    3'd3:    r = 8'hEB;
                    default: r = 8'h65;
                endcase
            end
            CH_O: begin
                case (idx)
                    3'd0:    r = 8'hF3;
                    3'd1:    r = 8'hF2;
                    3'd2:    r = 8'hF4;
                    3'd3:    r = 8'hF6;
                    default: r = 8'h6F;
                endcase
            end
            CH_C: begin
                case (idx)
                    3'd4:    r = 8'hE7;
                    default: r = 8'h63;
                endcase
            end
            default: r = letter;
        endcase
        return r;
    endfunction

endpackage

@@ src/dmd_parser.sv @@
// ----------------------------------------------------------------------------
// dmd_parser
// Markup parse state and the per-byte decode into a group of results.
// ----------------------------------------------------------------------------
module dmd_parser (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [1:0]      mode,
    input  logic            in_accept,
    input  logic [7:0]      in_byte,
    input  logic            entry_end,
    output dmd_pkg::group_t group
);
    import dmd_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic [2:0] cnt;
    logic       hw_mode;
    logic       raw_mode;
    logic [2:0] digit_idx;

    assign hw_mode   = (mode == MODE_HEAD);
    assign raw_mode  = (mode == MODE_RAW);
    assign digit_idx = 3'(in_byte - CH_ONE);

    always_comb begin
        group      = '0;
        cnt        = 3'd0;
        phase_next = phase_reg;
        held_next  = held_reg;

        if (phase_reg == PH_STOPPED) begin
            // rest of the entry is ignored
        end else if (raw_mode) begin
            phase_next = PH_NORMAL;
            group.kind[cnt[1:0]] = KIND_PLAIN;
            group.code[cnt[1:0]] = in_byte;
            cnt = cnt + 3'd1;
        end else begin
            // held space resolves first, then the byte runs from the new phase
            if (phase_reg == PH_SPACE) begin
                if (hw_mode && in_byte == CH_STAR) begin
                    group.kind[cnt[1:0]] = KIND_NEWLINE;
                    group.code[cnt[1:0]] = 8'h00;
                    cnt = cnt + 3'd1;
                    phase_next = PH_STOPPED;
                end else begin
                    group.kind[cnt[1:0]] = KIND_PLAIN;
                    group.code[cnt[1:0]] = CH_SPACE;
                    cnt = cnt + 3'd1;
                    phase_next = PH_NORMAL;
                end
            end
            case (phase_next)
                PH_NORMAL: begin
                    if (in_byte == CH_STAR) begin
                        phase_next = PH_STAR;
                    end else if (in_byte == CH_HASH) begin
                        phase_next = PH_HASH;
                    end else if (in_byte == CH_PLUS || in_byte == CH_LT) begin
                        phase_next = PH_NORMAL;
                    end else if (in_byte == CH_SPACE && hw_mode) begin
                        phase_next = PH_SPACE;
                    end else begin
                        group.kind[cnt[1:0]] = KIND_PLAIN;
                        group.code[cnt[1:0]] = in_byte;
                        cnt = cnt + 3'd1;
                        phase_next = PH_NORMAL;
                    end
                end
                PH_STAR: begin
                    if (hw_mode && in_byte != CH_L) begin
                        group.kind[cnt[1:0]] = KIND_NEWLINE;
                        group.code[cnt[1:0]] = 8'h00;
                        cnt = cnt + 3'd1;
                        phase_next = PH_STOPPED;
                    end else if (in_byte == CH_L) begin
                        if (!hw_mode) begin
                            group.kind[cnt[1:0]] = KIND_NEWLINE;
                            group.code[cnt[1:0]] = 8'h00;
                            cnt = cnt + 3'd1;
                        end
                        phase_next = PH_NORMAL;
                    end else if (in_byte == CH_S) begin
                        phase_next = PH_STAR_S;
                    end else begin
                        phase_next = PH_NORMAL;
                    end
                end
                PH_STAR_S: begin
                    group.kind[0] = KIND_PLAIN;
                    group.code[0] = CH_LPAREN;
                    group.kind[1] = KIND_PLAIN;
                    group.code[1] = in_byte;
                    group.kind[2] = KIND_PLAIN;
                    group.code[2] = CH_RPAREN;
                    cnt = 3'd3;
                    phase_next = PH_NORMAL;
                end
                PH_HASH: begin
                    held_next  = in_byte;
                    phase_next = PH_HASH_LETTER;
                end
                PH_HASH_LETTER: begin
                    if (in_byte >= CH_ONE && in_byte <= CH_FIVE) begin
                        if (held_reg == CH_A || held_reg == CH_E ||
                            held_reg == CH_O || held_reg == CH_C) begin
                            group.kind[cnt[1:0]] = KIND_RUNE;
                        end else begin
                            group.kind[cnt[1:0]] = KIND_PLAIN;
                        end
                        group.code[cnt[1:0]] = accent_rune(held_reg, digit_idx);
                        cnt = cnt + 3'd1;
                    end
                    phase_next = PH_NORMAL;
                end
                default: begin
                end
            endcase
        end

        if (entry_end) begin
            if (phase_next != PH_STOPPED) begin
                if (phase_next == PH_SPACE) begin
                    group.kind[cnt[1:0]] = KIND_PLAIN;
                    group.code[cnt[1:0]] = CH_SPACE;
                    cnt = cnt + 3'd1;
                end
                group.kind[cnt[1:0]] = KIND_NEWLINE;
                group.code[cnt[1:0]] = 8'h00;
                cnt = cnt + 3'd1;
            end
            phase_next = PH_NORMAL;
            held_next  = 8'h00;
        end
        group.count = cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_NORMAL;
            held_reg  <= 8'h00;
        end else if (in_accept) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

@@ src/dmd_out_buf.sv @@
// ----------------------------------------------------------------------------
// dmd_out_buf
// Result group register; hands the group out one word per handshake.
// ----------------------------------------------------------------------------
module dmd_out_buf (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  dmd_pkg::group_t group,
    output logic            can_load,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic [1:0]      m_tuser,
    output logic            m_tlast
);
    import dmd_pkg::*;

    group_t     grp_reg;
    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       last_word;

    assign last_word = (3'(idx_reg) == grp_reg.count - 3'd1);
    assign can_load  = !valid_reg || (m_tready && last_word);

    assign m_tvalid = valid_reg;
    assign m_tdata  = grp_reg.code[idx_reg];
    assign m_tuser  = grp_reg.kind[idx_reg];
    assign m_tlast  = last_word;

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (valid_reg && m_tready) begin
            if (last_word) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
        // groups with no results are never stored
        if (load && group.count != 3'd0) begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && group.count != 3'd0) begin
            grp_reg <= group;
        end
    end

endmodule

@@ src/dictionary_markup_decoder_core.sv @@
// ----------------------------------------------------------------------------
// dictionary_markup_decoder_core
// Thesaurus entry markup decoder, one markup byte in, up to four characters
// out.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one entry byte per word, s_tlast on the last byte of an
//   entry. Output stream: one character per word, m_tuser gives its kind
//   (plain byte, accented rune, newline), m_tlast marks the last character
//   caused by one input byte.
//   mode is written through cfg_we/cfg_wdata while the stream is quiet.
//   A byte is decoded in the cycle it is accepted; its first character is
//   presented on the next cycle. A byte yielding n characters (n up to 4,
//   e.g. "*S" argument at entry end) holds the output until all n are
//   taken; while the receiver is ready, bytes yielding none or one go at one
//   per cycle. The single result group register sets this: s_tready is high
//   while it is empty or its last word is being taken.
//   Reset empties the output register, clears the parse state and sets mode
//   to full entry. A stalled receiver holds the current word and, while the
//   register holds a group, holds s_tready low.
// ----------------------------------------------------------------------------
module dictionary_markup_decoder_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] code
    output logic [1:0] m_tuser,   // [1:0] kind
    output logic       m_tlast
);
    import dmd_pkg::*;

    logic [1:0] mode_reg;
    logic       in_accept;
    group_t     group;

    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_FULL;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata;
        end
    end

    dmd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mode      (mode_reg),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .entry_end (s_tlast),
        .group     (group)
    );

    dmd_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (in_accept),
        .group    (group),
        .can_load (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ src/dmd_checker.sv @@
// ----------------------------------------------------------------------------
// dmd_checker
// Port-level checks for the entry markup decoder, bound to the top level.
// ----------------------------------------------------------------------------
module dmd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);
    import dmd_pkg::*;

    // a stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_newline_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_NEWLINE |-> m_tdata == 8'h00)
        else $error("newline with non-zero code");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= KIND_NEWLINE)
        else $error("undefined result kind");

    // mid-group words block the input side
    a_group_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready while a group is still draining");

endmodule

bind dictionary_markup_decoder_core dmd_checker u_dmd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
